// ===== hw/rtl/rcwg_pkg.sv =====
package rcwg_pkg;

   // fixed field widths
   localparam int LEN_W     = 13;
   localparam int IDX_W     = 12;
   localparam int CSR_IDX_W = 2;

   // register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_LENGTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERIODIC = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BETA     = 2'd3;

   // phase divider: one quotient bit per stage, 33 bits to cover a full turn
   localparam int DIV_STEPS = 33;

   // cosine datapath constants, Q1.30
   localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
   localparam logic [29:0] OCT_HALF = 30'h2000_0000;
   localparam logic [33:0] PI_Q32   = 34'd13493037705;
   localparam int          PI_SPLIT = 17;
   localparam logic [16:0] PI_LO    = PI_Q32[16:0];
   localparam logic [16:0] PI_HI    = PI_Q32[33:17];
   localparam logic [29:0] X_MAX    = 30'd843314857;

   localparam int HORNER_STEPS = 6;

   // octant side information carried down the cosine pipeline
   typedef struct packed {
      logic        use_sin;
      logic        neg;
      logic [29:0] x;
      logic [29:0] x2;
   } side_type;

   // horner divisors, cosine series and sine series
   function automatic logic [7:0] horner_div(input logic use_sin, input logic [2:0] step);
      logic [7:0] d;
      case ({use_sin, step})
         4'b0_000: d = 8'd132;
         4'b0_001: d = 8'd90;
         4'b0_010: d = 8'd56;
         4'b0_011: d = 8'd30;
         4'b0_100: d = 8'd12;
         4'b0_101: d = 8'd2;
         4'b1_000: d = 8'd156;
         4'b1_001: d = 8'd110;
         4'b1_010: d = 8'd72;
         4'b1_011: d = 8'd42;
         4'b1_100: d = 8'd20;
         4'b1_101: d = 8'd6;
         default:  d = 8'd2;
      endcase
      return d;
   endfunction

   // floor(2^32 / divisor), quotient estimate is at most one short
   function automatic logic [31:0] horner_rcp(input logic use_sin, input logic [2:0] step);
      logic [31:0] m;
      case ({use_sin, step})
         4'b0_000: m = 32'd32537631;
         4'b0_001: m = 32'd47721858;
         4'b0_010: m = 32'd76695844;
         4'b0_011: m = 32'd143165576;
         4'b0_100: m = 32'd357913941;
         4'b0_101: m = 32'd2147483648;
         4'b1_000: m = 32'd27531841;
         4'b1_001: m = 32'd39045157;
         4'b1_010: m = 32'd59652323;
         4'b1_011: m = 32'd102261126;
         4'b1_100: m = 32'd214748364;
         4'b1_101: m = 32'd715827882;
         default:  m = 32'd2147483648;
      endcase
      return m;
   endfunction

endpackage

// ===== hw/rtl/raised_cosine_window_generator.sv =====
// throughput: one item per cycle while the pipeline is not held; the depth is
// set by the 33-stage restoring phase divider followed by six three-stage
// horner steps of the cosine series
// the whole pipeline holds while a result waits on rsp_ready
// reset (synchronous, active high) empties the pipeline and restores
// window length 1024, periodic, alpha = beta = 0.5
module raised_cosine_window_generator
   import rcwg_pkg::*;
#(
   parameter int MAX_LENGTH    = 4096,
   parameter int FRACTION_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [IDX_W-1:0] req_sample_index,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [FRACTION_BITS+1:0] rsp_coefficient,
   output logic rsp_index_out_of_range,
   input  logic csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [((FRACTION_BITS+2 > LEN_W) ? FRACTION_BITS+2 : LEN_W)-1:0] csr_wdata
);

   localparam int CW = FRACTION_BITS + 2;

   // stage numbering
   localparam int S_DIV0 = 0;
   localparam int S_C0   = S_DIV0 + DIV_STEPS + 1;
   localparam int S_C1   = S_C0 + 1;
   localparam int S_C2   = S_C1 + 1;
   localparam int S_C3   = S_C2 + 1;
   localparam int S_F1   = S_C3 + 3 * HORNER_STEPS + 1;
   localparam int S_F2   = S_F1 + 1;
   localparam int S_F3   = S_F2 + 1;
   localparam int NSTAGE = S_F3 + 1;

   localparam logic signed [CW+2:0] SAT_HI = (CW+3)'((64'sd1 <<< (CW-1)) - 64'sd1);
   localparam logic signed [CW+2:0] SAT_LO = -SAT_HI - (CW+3)'(1);
   localparam logic [CW-1:0] COEF_ONE      = CW'(64'd1 << FRACTION_BITS);
   localparam logic [CW-1:0] COEF_HALF     = CW'(64'd1 << (FRACTION_BITS - 1));

   // configuration registers
   logic [LEN_W-1:0]     len_ff;
   logic                 periodic_ff;
   logic signed [CW-1:0] alpha_ff;
   logic signed [CW-1:0] beta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= LEN_W'(1024);
         periodic_ff <= 1'b1;
         alpha_ff    <= COEF_HALF;
         beta_ff     <= COEF_HALF;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_LENGTH:   len_ff      <= csr_wdata[LEN_W-1:0];
            REG_PERIODIC: periodic_ff <= csr_wdata[0];
            REG_ALPHA:    alpha_ff    <= csr_wdata[CW-1:0];
            REG_BETA:     beta_ff     <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   // pipeline advance: everything moves unless a result is held
   logic en;
   logic [NSTAGE-1:0] vld_ff, oor_ff, one_ff;
   assign en        = rsp_ready | ~vld_ff[S_F3];
   assign req_ready = en;

   // input stage decode
   logic [LEN_W-1:0] len_clamp, den_in;
   logic             oor_in, one_in;
   always_comb begin
      len_clamp = (32'(len_ff) > MAX_LENGTH) ? LEN_W'(MAX_LENGTH) : len_ff;
      oor_in    = {1'b0, req_sample_index} >= len_clamp;
      one_in    = len_clamp == LEN_W'(1);
      den_in    = periodic_ff ? len_clamp : len_clamp - LEN_W'(1);
   end

   // valid and flag chains
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTAGE-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         oor_ff <= {oor_ff[NSTAGE-2:0], oor_in};
         one_ff <= {one_ff[NSTAGE-2:0], one_in};
      end
   end

   // restoring divider for the rounded phase (idx * 2^32 + den/2) / den
   logic [LEN_W-1:0] rem_ff [0:DIV_STEPS];
   logic [LEN_W-1:0] den_ff [0:DIV_STEPS];
   logic [32:0]      nb_ff  [0:DIV_STEPS];
   logic [31:0]      q_ff   [0:DIV_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {2'b00, req_sample_index[IDX_W-1:1]};
         den_ff[0] <= den_in;
         nb_ff[0]  <= {req_sample_index[0], 20'd0, den_in[LEN_W-1:1]};
         q_ff[0]   <= '0;
      end
   end

   for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_div
      logic [LEN_W:0] trial;
      logic           ge;
      always_comb begin
         trial = {rem_ff[s-1], nb_ff[s-1][32]};
         ge    = trial >= {1'b0, den_ff[s-1]};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= ge ? LEN_W'(trial - {1'b0, den_ff[s-1]}) : trial[LEN_W-1:0];
            den_ff[s] <= den_ff[s-1];
            nb_ff[s]  <= {nb_ff[s-1][31:0], 1'b0};
            q_ff[s]   <= {q_ff[s-1][30:0], ge};
         end
      end
   end

   // octant reduction and angle scaling
   side_type    sd_ff [S_C0:S_F1-1];
   logic [46:0] pa_ff, pb_ff;
   logic [59:0] xx_ff;
   logic [30:0] ht_ff [0:HORNER_STEPS];

   logic [31:0] ph;
   logic        fold;
   logic [29:0] g_in;
   logic [64:0] xs_in;
   logic [60:0] x2r_in;
   always_comb begin
      ph     = q_ff[DIV_STEPS];
      fold   = ph[29:0] > OCT_HALF;
      g_in   = fold ? 30'(Q30_ONE - {1'b0, ph[29:0]}) : ph[29:0];
      xs_in  = {1'b0, pa_ff, {PI_SPLIT{1'b0}}} + 65'(pb_ff) + (65'd1 << 32);
      x2r_in = {1'b0, xx_ff} + (61'd1 << 29);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff       <= 47'(g_in) * 47'(PI_HI);
         pb_ff       <= 47'(g_in) * 47'(PI_LO);
         sd_ff[S_C0] <= '{use_sin: ph[30] ^ fold, neg: ph[31] ^ ph[30], x: '0, x2: '0};
         sd_ff[S_C1] <= '{use_sin: sd_ff[S_C0].use_sin, neg: sd_ff[S_C0].neg,
                          x: xs_in[62:33], x2: sd_ff[S_C0].x2};
         xx_ff       <= 60'(sd_ff[S_C1].x) * 60'(sd_ff[S_C1].x);
         sd_ff[S_C2] <= sd_ff[S_C1];
         sd_ff[S_C3] <= '{use_sin: sd_ff[S_C2].use_sin, neg: sd_ff[S_C2].neg,
                          x: sd_ff[S_C2].x, x2: x2r_in[59:30]};
         ht_ff[0]    <= Q30_ONE;
      end
   end

   // horner steps: product, reciprocal multiply, correction
   logic [29:0] hp_ff  [0:HORNER_STEPS-1];
   logic [29:0] hpp_ff [0:HORNER_STEPS-1];
   logic [61:0] hm_ff  [0:HORNER_STEPS-1];

   for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
      localparam int SA = S_C3 + 3 * k + 1;
      logic [60:0] prod;
      logic [29:0] qe, qc;
      logic [7:0]  d;
      logic [30:0] r;
      always_comb begin
         prod = 61'(sd_ff[SA-1].x2) * 61'(ht_ff[k]);
         d    = horner_div(sd_ff[SA+1].use_sin, 3'(k));
         qe   = hm_ff[k][61:32];
         r    = {1'b0, hpp_ff[k]} - 31'(38'(qe) * 38'(d));
         qc   = (r >= 31'(d)) ? qe + 30'd1 : qe;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            hp_ff[k]    <= prod[59:30];
            sd_ff[SA]   <= sd_ff[SA-1];
            hm_ff[k]    <= 62'(hp_ff[k]) * 62'(horner_rcp(sd_ff[SA].use_sin, 3'(k)));
            hpp_ff[k]   <= hp_ff[k];
            sd_ff[SA+1] <= sd_ff[SA];
            ht_ff[k+1]  <= Q30_ONE - {1'b0, qc};
            sd_ff[SA+2] <= sd_ff[SA+1];
         end
      end
   end

   // magnitude, sign, beta product, rounding, saturation, out of range and length one cases
   logic [30:0]           mag_ff;
   logic                  neg_ff;
   logic signed [CW+31:0] bprod_ff;
   logic [CW-1:0]         coef_ff;

   logic [60:0]           sinp_in;
   logic signed [31:0]    cv_in;
   logic signed [CW+32:0] v_in, vr_in;
   logic signed [CW+2:0]  r_in;
   logic [CW-1:0]         sat_in, coef_in;
   always_comb begin
      sinp_in = 61'(sd_ff[S_F1-1].x) * 61'(ht_ff[HORNER_STEPS]);
      cv_in   = neg_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});
      v_in    = ((CW+33)'(alpha_ff) <<< 30) - (CW+33)'(bprod_ff);
      vr_in   = v_in + (CW+33)'(64'sd1 <<< 29);
      r_in    = vr_in[CW+32:30];
      if (r_in > SAT_HI) begin
         sat_in = SAT_HI[CW-1:0];
      end else if (r_in < SAT_LO) begin
         sat_in = SAT_LO[CW-1:0];
      end else begin
         sat_in = r_in[CW-1:0];
      end
      if (oor_ff[S_F2]) begin
         coef_in = '0;
      end else if (one_ff[S_F2]) begin
         coef_in = COEF_ONE;
      end else begin
         coef_in = sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff   <= sd_ff[S_F1-1].use_sin ? sinp_in[60:30] : ht_ff[HORNER_STEPS];
         neg_ff   <= sd_ff[S_F1-1].neg;
         bprod_ff <= (CW+32)'(beta_ff) * (CW+32)'(cv_in);
         coef_ff  <= coef_in;
      end
   end

   assign rsp_valid              = vld_ff[S_F3];
   assign rsp_coefficient        = coef_ff;
   assign rsp_index_out_of_range = oor_ff[S_F3];

   // checks
   a_empty_after_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_out_of_range |-> rsp_coefficient == '0)
      else $error("out of range item with non-zero coefficient");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] && !oor_ff[0] && !one_ff[0] |-> rem_ff[0] < den_ff[0])
      else $error("divider started with remainder not below denominator");

   a_angle_octant: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_C1] |-> sd_ff[S_C1].x <= X_MAX)
      else $error("reduced angle beyond one octant");

endmodule

// ===== verif/tb_raised_cosine_window_generator.sv =====
module tb_raised_cosine_window_generator;
   import rcwg_pkg::*;

   localparam int CW = 18;
   localparam int WW = (CW > LEN_W) ? CW : LEN_W;
   localparam int LATENCY = 58;

   typedef struct {
      logic signed [CW-1:0] coef;
      logic                 oor;
   } coef_exp_type;

   // window coefficient scoreboard: holds a copy of the registers
   class window_scoreboard;
      logic [LEN_W-1:0]     length_q;
      logic                 periodic_q;
      logic signed [CW-1:0] alpha_q;
      logic signed [CW-1:0] beta_q;
      coef_exp_type         pending[$];
      int                   errors;
      int                   checked;

      function void restore_defaults();
         length_q   = 13'd1024;
         periodic_q = 1'b1;
         alpha_q    = 18'sd32768;
         beta_q     = 18'sd32768;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [WW-1:0] data);
         case (idx)
            REG_LENGTH:   length_q = data[LEN_W-1:0];
            REG_PERIODIC: periodic_q = data[0];
            REG_ALPHA:    alpha_q = data[CW-1:0];
            REG_BETA:     beta_q = data[CW-1:0];
         endcase
      endfunction

      // truncated taylor series in q30, horner steps truncating
      function automatic longint unsigned series(bit sin_s, longint unsigned x);
         longint unsigned dc[6];
         longint unsigned ds[6];
         longint unsigned x2, t;
         dc = '{132, 90, 56, 30, 12, 2};
         ds = '{156, 110, 72, 42, 20, 6};
         x2 = (x * x + (64'd1 << 29)) >> 30;
         t = 64'd1 << 30;
         for (int k = 0; k < 6; k++)
            t = (64'd1 << 30) - ((x2 * t) >> 30) / (sin_s ? ds[k] : dc[k]);
         return sin_s ? (x * t) >> 30 : t;
      endfunction

      // cosine of a 32-bit fraction of a turn, q30 signed
      function automatic longint turn_cosine(logic [31:0] ph);
         logic [1:0]      quad;
         longint unsigned f, g, x, mag;
         bit              use_sin, neg;
         quad = ph[31:30];
         f = ph[29:0];
         use_sin = quad[0];
         neg = (quad == 2'd1 || quad == 2'd2);
         g = f;
         if (f > (64'd1 << 29)) begin
            g = (64'd1 << 30) - f;
            use_sin = !use_sin;
         end
         x = (g * 64'd13493037705 + (64'd1 << 32)) >> 33;
         mag = series(use_sin, x);
         return neg ? -longint'(mag) : longint'(mag);
      endfunction

      function automatic coef_exp_type window_value(logic [IDX_W-1:0] idx);
         coef_exp_type    e;
         longint unsigned len, den, ph;
         longint          cv, v, r;
         len = length_q;
         if (len > 4096) len = 4096;
         e.oor = 1'b0;
         if (idx >= len) begin
            e.coef = '0;
            e.oor = 1'b1;
            return e;
         end
         if (len == 1) begin
            e.coef = 18'sd65536;
            return e;
         end
         den = periodic_q ? len : len - 1;
         ph = ((longint'(idx) << 32) + (den >> 1)) / den;
         cv = turn_cosine(ph[31:0]);
         v = longint'(alpha_q) * (longint'(1) << 30) - longint'(beta_q) * cv;
         r = (v + (longint'(1) << 29)) >>> 30;
         if (r > 131071) r = 131071;
         if (r < -131072) r = -131072;
         e.coef = r[CW-1:0];
         return e;
      endfunction

      function void note_item(logic [IDX_W-1:0] idx);
         pending.push_back(window_value(idx));
      endfunction

      function void check_result(logic signed [CW-1:0] coef, logic oor);
         coef_exp_type e;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result coef %0d oor %0b", $time, coef, oor);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (coef !== e.coef) begin
            $display("%0t: coefficient expected %0d actual %0d", $time, e.coef, coef);
            errors++;
         end
         if (oor !== e.oor) begin
            $display("%0t: out of range flag expected %0b actual %0b", $time, e.oor, oor);
            errors++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [IDX_W-1:0]     req_sample_index;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic signed [CW-1:0] rsp_coefficient;
   logic                 rsp_index_out_of_range;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WW-1:0]        csr_wdata;

   window_scoreboard sb;
   int  send_idle;
   int  recv_stall;
   int  hold_req;
   int  sent;

   raised_cosine_window_generator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_sample_index(req_sample_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_coefficient(rsp_coefficient),
      .rsp_index_out_of_range(rsp_index_out_of_range),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #(8 * 2000000);
      $display("raised_cosine_window_generator test failed");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int hold_taken;
      hold_taken = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_taken) begin
            hold_taken = hold_req;
            rsp_ready = 1'b0;
            repeat (300) @(negedge clock);
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_stall);
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_coefficient, rsp_index_out_of_range);
   end

   task automatic send_item(logic [IDX_W-1:0] idx);
      if ($urandom_range(99) < send_idle)
         repeat ($urandom_range(1, 4)) @(negedge clock);
      req_valid = 1'b1;
      req_sample_index = idx;
      do @(posedge clock); while (!req_ready);
      sb.note_item(idx);
      sent++;
      @(negedge clock);
      req_valid = 1'b0;
      req_sample_index = IDX_W'($urandom);
   endtask

   task automatic wait_drained();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [WW-1:0] data);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic set_window(int len, bit per, int a, int b);
      write_csr(REG_LENGTH, WW'(len));
      write_csr(REG_PERIODIC, WW'(per));
      write_csr(REG_ALPHA, a[CW-1:0]);
      write_csr(REG_BETA, b[CW-1:0]);
   endtask

   // mostly indexes inside the window, some anywhere
   task automatic send_random(int count);
      int len;
      for (int n = 0; n < count; n++) begin
         len = (sb.length_q > 4096) ? 4096 : sb.length_q;
         if (len > 0 && $urandom_range(99) < 75)
            send_item(IDX_W'($urandom_range(len - 1)));
         else
            send_item(IDX_W'($urandom));
      end
   endtask

   initial begin
      int lens[10];
      int pers[10];
      int alphas[10];
      int betas[10];
      sb = new();
      sb.restore_defaults();
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_index = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle = 0;
      recv_stall = 0;
      sent = 0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // directed: reset window, both index extremes and quarter points
      foreach (lens[k]) lens[k] = 0;
      send_item(0);
      send_item(4095);
      send_item(1024);
      send_item(1023);
      send_item(512);
      send_item(256);
      send_item(768);
      send_item(1);
      wait_drained();
      // length one, symmetric length two wrap, length zero, length above max, length at max
      set_window(1, 0, 32768, 32768);
      send_item(0);
      send_item(1);
      wait_drained();
      set_window(2, 0, 35389, 30147);
      send_item(0);
      send_item(1);
      send_item(2);
      wait_drained();
      set_window(0, 1, 32768, 32768);
      send_item(0);
      send_item(4095);
      wait_drained();
      set_window(8191, 1, 131071, -131072);
      send_item(0);
      send_item(2048);
      send_item(4095);
      wait_drained();
      set_window(4096, 0, -131072, 131071);
      send_item(0);
      send_item(2048);
      send_item(4095);

      lens   = '{1024, 4096, 1, 2, 7, 4096, 8191, 0, 300, 4096};
      pers   = '{1, 0, 1, 0, 1, 1, 0, 1, 0, 1};
      alphas = '{32768, 35389, 32768, 131071, -131072, 0, 35389, 32768, 12345, 0};
      betas  = '{32768, 30147, 0, -131072, 131071, 131071, 30147, 32768, -54321, 0};
      for (int p = 0; p < 10; p++) begin
         wait_drained();
         if (p == 9)
            set_window($urandom_range(4096), 1'($urandom_range(1)),
                       $urandom_range(262143) - 131072, $urandom_range(262143) - 131072);
         else
            set_window(lens[p], pers[p], alphas[p], betas[p]);
         case (p % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 53; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 53; end
            default: begin send_idle = 20; recv_stall = 20; end
         endcase
         if (p == 4) begin
            send_idle = 0;
            hold_req++;
         end
         send_random(75);
         if (p == 6) wait_drained();
         send_random(75);
      end

      wait_drained();
      $display("covered %0d items over ten register settings and four idling mixes,", sent);
      $display("%0d results checked, including a long receiver hold-off", sb.checked);
      if (sb.errors == 0)
         $display("raised_cosine_window_generator test passed");
      else
         $display("raised_cosine_window_generator test failed");
      $finish;
   end

endmodule
